@@ design/pca_pkg.sv @@
// Shared types and codes for the PID controller with anti-windup.
package pca_pkg;

  // Operation codes carried in in_tuser
  localparam logic [1:0] OP_REGULATE   = 2'd0;
  localparam logic [1:0] OP_SYNC_TRACK = 2'd1;
  localparam logic [1:0] OP_SYNC_RUN   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN       = 3'd0;
  localparam logic [2:0] REG_INT_GAIN   = 3'd1;
  localparam logic [2:0] REG_DER_GAIN   = 3'd2;
  localparam logic [2:0] REG_MARGIN     = 3'd3;
  localparam logic [2:0] REG_OUT_MAX    = 3'd4;
  localparam logic [2:0] REG_OUT_MIN    = 3'd5;

  // Integrator block codes (2-bit two's complement)
  localparam logic [1:0] BLK_NONE = 2'b00;
  localparam logic [1:0] BLK_POS  = 2'b01;
  localparam logic [1:0] BLK_NEG  = 2'b11;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

endpackage

@@ design/pid_controller_antiwindup.sv @@
// Top level of the PID regulator with integrator anti-windup.
//
// Input stream (in_*): one word is one command. in_tuser carries the opcode
// (regulate, sync to tracked drive, sync while running); in_tdata carries
// error, track value and external block flag. in_tready is high only while
// the sequencer is idle; one command is worked on at a time.
// Result stream (out_*): exactly one word per command, the drive value and
// the internal block state, held in an output register until taken.
// A new command is accepted while a result still waits; its own result is
// written only after the previous one has left, so a stalled receiver just
// holds the sequencer at its final step.
// Configuration (cfg_*): index plus data, always ready; write while idle.
// Arithmetic: all math runs through one shared multiply/divide unit. A multiply
// consumes one 16-bit chunk of the multiplier per cycle, a divide yields
// one quotient bit per cycle. A regulate command runs no divide with the
// integral path off and up to four divides (integrator clamp plus both
// back-computations when the limits cross); a sync runs at most one divide.
// Reset (rst_n low, synchronous) restores the default gains and limits,
// clears integrator, error history, last output and block state, and drops
// any pending result.
module pid_controller_antiwindup import pca_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: error, track_value, ext_block (low bits first), zero padded
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] in_tdata,
  // in_tuser: opcode
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: drive, int_block (low bits first), zero padded
  output logic [((DATA_WIDTH+2+7)/8)*8-1:0]   out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_addr,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int W   = DW + 16;
  localparam int OTW = ((DW + 2 + 7) / 8) * 8;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE = DW'(1) << F;

  typedef enum logic [25:0] {
    ST_IDLE   = 26'd1 << 0,
    ST_KKI    = 26'd1 << 1,
    ST_DM     = 26'd1 << 2,
    ST_LIM    = 26'd1 << 3,
    ST_R_INT  = 26'd1 << 4,
    ST_R_DLO  = 26'd1 << 5,
    ST_R_DHI  = 26'd1 << 6,
    ST_R_BND  = 26'd1 << 7,
    ST_R_P    = 26'd1 << 8,
    ST_R_KI   = 26'd1 << 9,
    ST_R_PI   = 26'd1 << 10,
    ST_R_KD   = 26'd1 << 11,
    ST_R_D    = 26'd1 << 12,
    ST_R_RES  = 26'd1 << 13,
    ST_R_AWH  = 26'd1 << 14,
    ST_R_AWHD = 26'd1 << 15,
    ST_R_AWL  = 26'd1 << 16,
    ST_R_AWLD = 26'd1 << 17,
    ST_R_FIN  = 26'd1 << 18,
    ST_S1_P   = 26'd1 << 19,
    ST_S1_CHK = 26'd1 << 20,
    ST_S1_DIV = 26'd1 << 21,
    ST_S2_D   = 26'd1 << 22,
    ST_S2_PD  = 26'd1 << 23,
    ST_S2_DIV = 26'd1 << 24,
    ST_SY_FIN = 26'd1 << 25
  } st_t;

  function automatic logic signed [W-1:0] wadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) wadd = s[W] ? SMIN : SMAX;
    else wadd = $signed(s[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] wsub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) wsub = s[W] ? SMIN : SMAX;
    else wsub = $signed(s[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] bound(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] lo,
                                                input logic signed [W-1:0] hi);
    if (x < lo) bound = lo;
    else if (x > hi) bound = hi;
    else bound = x;
  endfunction

  // configuration
  logic signed [DW-1:0] gain_r, ki_r, kd_r, omax_r, omin_r;
  logic [F:0]           margin_r;

  // controller state
  logic signed [W-1:0]  integ_r, integ_nxt;
  logic signed [DW-1:0] le_r, le_nxt, ebl_r, ebl_nxt, lout_r, lout_nxt;
  logic [1:0]           bs_r, bs_nxt;

  // latched command
  logic [1:0]           op_r, op_nxt;
  logic signed [DW-1:0] e_r, e_nxt, trk_r, trk_nxt;
  logic [1:0]           ext_r, ext_nxt;

  // scratch
  logic signed [W-1:0] kki_r, kki_nxt, dm_r, dm_nxt, hi_r, hi_nxt, lo_r, lo_nxt;
  logic signed [W-1:0] p_r, p_nxt, pi_r, pi_nxt, res_r, res_nxt;
  logic signed [W-1:0] t1_r, t1_nxt, t2_r, t2_nxt;

  st_t  st_r, st_nxt;
  logic wait_r, wait_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [DW-1:0]    out_drive_r, out_drive_nxt;
  logic [1:0]       out_blk_r, out_blk_nxt;

  md_req_t             md_req;
  logic signed [W-1:0] md_a, md_b, md_res;
  logic                md_done;

  logic signed [W-1:0] gain_w, ki_w, kd_w, omax_w, omin_w, margin_w;
  logic signed [W-1:0] e_w, le_w, ebl_w, trk_w, lout_w, dif, res_b;
  logic                in_acc, out_free, kki_zero, blk_dif;

  assign gain_w   = W'(gain_r);
  assign ki_w     = W'(ki_r);
  assign kd_w     = W'(kd_r);
  assign omax_w   = W'(omax_r);
  assign omin_w   = W'(omin_r);
  assign margin_w = $signed(W'(margin_r));
  assign e_w      = W'(e_r);
  assign le_w     = W'(le_r);
  assign ebl_w    = W'(ebl_r);
  assign trk_w    = W'(trk_r);
  assign lout_w   = W'(lout_r);

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign kki_zero  = (kki_r == '0);
  // hold the integrator when the last error pushes into a blocked direction
  assign blk_dif   = ((bs_r == BLK_POS || ext_r == BLK_POS) && le_r > 0) ||
                     ((bs_r == BLK_NEG || ext_r == BLK_NEG) && le_r < 0);
  assign dif       = blk_dif ? '0 : le_w;
  assign res_b     = bound(res_r, omin_w, omax_w);

  always_comb begin
    st_nxt        = st_r;
    integ_nxt     = integ_r;
    le_nxt        = le_r;
    ebl_nxt       = ebl_r;
    lout_nxt      = lout_r;
    bs_nxt        = bs_r;
    op_nxt        = op_r;
    e_nxt         = e_r;
    trk_nxt       = trk_r;
    ext_nxt       = ext_r;
    kki_nxt       = kki_r;
    dm_nxt        = dm_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    p_nxt         = p_r;
    pi_nxt        = pi_r;
    res_nxt       = res_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_drive_nxt = out_drive_r;
    out_blk_nxt   = out_blk_r;
    md_req.start  = 1'b0;
    md_req.op     = MD_MUL;
    md_a          = '0;
    md_b          = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_tuser;
          e_nxt   = in_tdata[DW-1:0];
          trk_nxt = in_tdata[2*DW-1:DW];
          ext_nxt = in_tdata[2*DW+1:2*DW];
          st_nxt  = ST_KKI;
        end
      end
      ST_KKI: begin
        md_a = gain_w;
        md_b = ki_w;
        md_req.start = !wait_r;
        if (md_done) begin
          kki_nxt = md_res;
          st_nxt  = ST_DM;
        end
      end
      ST_DM: begin
        md_a = margin_w;
        md_b = wsub(omax_w, omin_w);
        md_req.start = !wait_r;
        if (md_done) begin
          dm_nxt = md_res;
          st_nxt = ST_LIM;
        end
      end
      ST_LIM: begin
        hi_nxt = wadd(omax_w, dm_r);
        lo_nxt = wsub(omin_w, dm_r);
        unique case (op_r)
          OP_REGULATE:   st_nxt = ST_R_INT;
          OP_SYNC_TRACK: st_nxt = ST_S1_P;
          OP_SYNC_RUN:   st_nxt = ST_S2_D;
          default:       st_nxt = ST_SY_FIN;
        endcase
      end
      // regulate
      ST_R_INT: begin
        integ_nxt = wadd(integ_r, dif);
        st_nxt    = kki_zero ? ST_R_P : ST_R_DLO;
      end
      ST_R_DLO: begin
        md_req.op = MD_DIV;
        md_a = lo_r;
        md_b = kki_r;
        md_req.start = !wait_r;
        if (md_done) begin
          t1_nxt = md_res;
          st_nxt = ST_R_DHI;
        end
      end
      ST_R_DHI: begin
        md_req.op = MD_DIV;
        md_a = hi_r;
        md_b = kki_r;
        md_req.start = !wait_r;
        if (md_done) begin
          t2_nxt = md_res;
          st_nxt = ST_R_BND;
        end
      end
      ST_R_BND: begin
        integ_nxt = bound(integ_r, t1_r, t2_r);
        st_nxt    = ST_R_P;
      end
      ST_R_P: begin
        md_a = gain_w;
        md_b = e_w;
        md_req.start = !wait_r;
        if (md_done) begin
          p_nxt  = md_res;
          st_nxt = ST_R_KI;
        end
      end
      ST_R_KI: begin
        md_a = kki_r;
        md_b = integ_r;
        md_req.start = !wait_r;
        if (md_done) begin
          t1_nxt = md_res;
          st_nxt = ST_R_PI;
        end
      end
      ST_R_PI: begin
        pi_nxt = wadd(p_r, t1_r);
        st_nxt = ST_R_KD;
      end
      ST_R_KD: begin
        md_a = gain_w;
        md_b = kd_w;
        md_req.start = !wait_r;
        if (md_done) begin
          t1_nxt = md_res;
          st_nxt = ST_R_D;
        end
      end
      ST_R_D: begin
        md_a = t1_r;
        md_b = wsub(e_w, le_w);
        md_req.start = !wait_r;
        if (md_done) begin
          t2_nxt = md_res;
          st_nxt = ST_R_RES;
        end
      end
      ST_R_RES: begin
        res_nxt = wadd(pi_r, t2_r);
        st_nxt  = ST_R_AWH;
      end
      ST_R_AWH: begin
        // upper anti-windup: reset or back-compute the integrator
        st_nxt = ST_R_AWL;
        if (integ_r >= 0 && pi_r > hi_r) begin
          if (p_r > omax_w || kki_zero) begin
            integ_nxt = '0;
            res_nxt   = p_r;
          end else begin
            res_nxt = omax_w;
            st_nxt  = ST_R_AWHD;
          end
        end
      end
      ST_R_AWHD: begin
        md_req.op = MD_DIV;
        md_a = wsub(omax_w, p_r);
        md_b = kki_r;
        md_req.start = !wait_r;
        if (md_done) begin
          integ_nxt = md_res;
          st_nxt    = ST_R_AWL;
        end
      end
      ST_R_AWL: begin
        st_nxt = ST_R_FIN;
        if (integ_r <= 0 && pi_r < lo_r) begin
          if (p_r < omin_w || kki_zero) begin
            integ_nxt = '0;
            res_nxt   = p_r;
          end else begin
            res_nxt = omin_w;
            st_nxt  = ST_R_AWLD;
          end
        end
      end
      ST_R_AWLD: begin
        md_req.op = MD_DIV;
        md_a = wsub(omin_w, p_r);
        md_b = kki_r;
        md_req.start = !wait_r;
        if (md_done) begin
          integ_nxt = md_res;
          st_nxt    = ST_R_FIN;
        end
      end
      ST_R_FIN: begin
        if (out_free) begin
          if (pi_r > hi_r) bs_nxt = BLK_POS;
          else if (pi_r < lo_r) bs_nxt = BLK_NEG;
          else bs_nxt = BLK_NONE;
          ebl_nxt       = le_r;
          le_nxt        = e_r;
          lout_nxt      = res_b[DW-1:0];
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_b[DW-1:0];
          out_blk_nxt   = bs_nxt;
          st_nxt        = ST_IDLE;
        end
      end
      // sync to tracked drive
      ST_S1_P: begin
        if (kki_zero) begin
          integ_nxt = '0;
          st_nxt    = ST_SY_FIN;
        end else begin
          md_a = gain_w;
          md_b = le_w;
          md_req.start = !wait_r;
          if (md_done) begin
            t1_nxt = md_res;
            st_nxt = ST_S1_CHK;
          end
        end
      end
      ST_S1_CHK: begin
        if (!(t1_r < dm_r && wsub('0, t1_r) < dm_r)) begin
          integ_nxt = '0;
          st_nxt    = ST_SY_FIN;
        end else begin
          md_a = gain_w;
          md_b = e_w;
          md_req.start = !wait_r;
          if (md_done) begin
            t2_nxt = md_res;
            st_nxt = ST_S1_DIV;
          end
        end
      end
      ST_S1_DIV: begin
        md_req.op = MD_DIV;
        md_a = wsub(trk_w, t2_r);
        md_b = kki_r;
        md_req.start = !wait_r;
        if (md_done) begin
          integ_nxt = md_res;
          st_nxt    = ST_SY_FIN;
        end
      end
      // sync while running
      ST_S2_D: begin
        if (kki_zero) begin
          integ_nxt = '0;
          st_nxt    = ST_SY_FIN;
        end else begin
          md_a = kd_w;
          md_b = wsub(le_w, ebl_w);
          md_req.start = !wait_r;
          if (md_done) begin
            t2_nxt = md_res;
            st_nxt = ST_S2_PD;
          end
        end
      end
      ST_S2_PD: begin
        md_a = gain_w;
        md_b = wadd(le_w, t2_r);
        md_req.start = !wait_r;
        if (md_done) begin
          t1_nxt = md_res;
          st_nxt = ST_S2_DIV;
        end
      end
      ST_S2_DIV: begin
        if (!(t1_r > wsub('0, dm_r) && t1_r < omax_w)) begin
          integ_nxt = '0;
          st_nxt    = ST_SY_FIN;
        end else begin
          md_req.op = MD_DIV;
          md_a = wsub(lout_w, t1_r);
          md_b = kki_r;
          md_req.start = !wait_r;
          if (md_done) begin
            integ_nxt = md_res;
            st_nxt    = ST_SY_FIN;
          end
        end
      end
      ST_SY_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = bs_r;
          out_drive_nxt = lout_r;
          if (op_r == OP_SYNC_TRACK) begin
            ebl_nxt       = e_r;
            le_nxt        = e_r;
            lout_nxt      = trk_r;
            out_drive_nxt = trk_r;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    wait_nxt = wait_r;
    if (md_req.start) wait_nxt = 1'b1;
    if (md_done) wait_nxt = 1'b0;
  end

  pca_muldiv #(
    .W (W),
    .F (F)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .opa    (md_a),
    .opb    (md_b),
    .done   (md_done),
    .result (md_res)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= ONE;
      ki_r        <= '0;
      kd_r        <= '0;
      margin_r    <= '0;
      omax_r      <= ONE;
      omin_r      <= -ONE;
      st_r        <= ST_IDLE;
      wait_r      <= 1'b0;
      integ_r     <= '0;
      le_r        <= '0;
      ebl_r       <= '0;
      lout_r      <= '0;
      bs_r        <= BLK_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_addr)
          REG_GAIN:     gain_r   <= cfg_data;
          REG_INT_GAIN: ki_r     <= cfg_data;
          REG_DER_GAIN: kd_r     <= cfg_data;
          REG_MARGIN:   margin_r <= cfg_data[F:0];
          REG_OUT_MAX:  omax_r   <= cfg_data;
          REG_OUT_MIN:  omin_r   <= cfg_data;
          default: ;
        endcase
      end
      st_r        <= st_nxt;
      wait_r      <= wait_nxt;
      integ_r     <= integ_nxt;
      le_r        <= le_nxt;
      ebl_r       <= ebl_nxt;
      lout_r      <= lout_nxt;
      bs_r        <= bs_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    e_r         <= e_nxt;
    trk_r       <= trk_nxt;
    ext_r       <= ext_nxt;
    kki_r       <= kki_nxt;
    dm_r        <= dm_nxt;
    hi_r        <= hi_nxt;
    lo_r        <= lo_nxt;
    p_r         <= p_nxt;
    pi_r        <= pi_nxt;
    res_r       <= res_nxt;
    t1_r        <= t1_nxt;
    t2_r        <= t2_nxt;
    out_drive_r <= out_drive_nxt;
    out_blk_r   <= out_blk_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OTW'({out_blk_r, out_drive_r});

endmodule

@@ design/pca_muldiv.sv @@
// Shared multi-cycle fixed-point multiply / divide unit with saturation.
module pca_muldiv import pca_pkg::*; #(
  parameter int W = 48,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  md_req_t             req,
  input  logic signed [W-1:0] opa,
  input  logic signed [W-1:0] opb,
  output logic                done,
  output logic signed [W-1:0] result
);

  localparam int N  = (W + 15) / 16;
  localparam int PW = N * 16;
  localparam int AW = W + PW;
  localparam int QW = W + F;
  localparam int MW = (AW > QW) ? AW : QW;
  localparam int XW = MW + 1;
  localparam int CW = $clog2(QW + 1);

  localparam logic [XW-1:0] POS_LIM = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [XW-1:0] NEG_LIM = POS_LIM + XW'(1);
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_FIN  = 4'b1000
  } ust_t;

  ust_t st_r, st_nxt;
  logic [W-1:0]  ua_r, ua_nxt;
  logic [PW-1:0] ub_r, ub_nxt;
  logic [W-1:0]  ud_r, ud_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [QW-1:0] num_r, num_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          neg_r, neg_nxt;
  logic          mul_r, mul_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic signed [W-1:0] res_r, res_nxt;

  logic [W-1:0]    amag, bmag;
  logic [W+15:0]   pprod, upper;
  logic [W:0]      rem2;
  logic            ge;
  logic [AW:0]     rnd;
  logic [XW-1:0]   mfin;
  logic [W-1:0]    mlow;

  assign amag  = opa[W-1] ? W'(-opa) : W'(opa);
  assign bmag  = opb[W-1] ? W'(-opb) : W'(opb);
  assign pprod = (W+16)'(ua_r) * (W+16)'(ub_r[15:0]);
  assign upper = (W+16)'(acc_r[AW-1:PW]) + pprod;
  assign rem2  = {rem_r, num_r[QW-1]};
  assign ge    = rem2 >= {1'b0, ud_r};
  assign rnd   = {1'b0, acc_r} + ((AW+1)'(1) << (F-1));
  assign mfin  = mul_r ? XW'(rnd >> F) : XW'(q_r);
  assign mlow  = mfin[W-1:0];

  always_comb begin
    st_nxt   = st_r;
    ua_nxt   = ua_r;
    ub_nxt   = ub_r;
    ud_nxt   = ud_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    mul_nxt  = mul_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    unique case (st_r)
      U_IDLE: begin
        if (req.start) begin
          ua_nxt  = amag;
          ub_nxt  = PW'(bmag);
          ud_nxt  = bmag;
          acc_nxt = '0;
          rem_nxt = '0;
          num_nxt = {amag, {F{1'b0}}};
          q_nxt   = '0;
          neg_nxt = opa[W-1] ^ opb[W-1];
          mul_nxt = (req.op == MD_MUL);
          cnt_nxt = '0;
          st_nxt  = (req.op == MD_MUL) ? U_MUL : U_DIV;
        end
      end
      U_MUL: begin
        // consume 16 bits of the multiplier per cycle, low chunk first
        acc_nxt = {upper, acc_r[PW-1:16]};
        ub_nxt  = ub_r >> 16;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(N - 1)) st_nxt = U_FIN;
      end
      U_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_nxt = ge ? W'(rem2 - {1'b0, ud_r}) : rem2[W-1:0];
        q_nxt   = {q_r[QW-2:0], ge};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(QW - 1)) st_nxt = U_FIN;
      end
      U_FIN: begin
        if (neg_r) begin
          res_nxt = (mfin > NEG_LIM) ? SMIN : -$signed(mlow);
        end else begin
          res_nxt = (mfin > POS_LIM) ? SMAX : $signed(mlow);
        end
        done_nxt = 1'b1;
        st_nxt   = U_IDLE;
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    ua_r  <= ua_nxt;
    ub_r  <= ub_nxt;
    ud_r  <= ud_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    mul_r <= mul_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
